// ===== hdl/timed_step_sequencer_top_defines.svh =====
// Assertion macros used by the timed step sequencer core.
`ifndef TIMED_STEP_SEQUENCER_TOP_DEFINES_SVH
`define TIMED_STEP_SEQUENCER_TOP_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define TSS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define TSS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== hdl/tss_pkg.sv =====
// Types and codes of the timed step sequencer.
package tss_pkg;

    localparam logic [2:0] OP_TICK  = 3'd0;
    localparam logic [2:0] OP_ADD   = 3'd1;
    localparam logic [2:0] OP_START = 3'd2;
    localparam logic [2:0] OP_STOP  = 3'd3;
    localparam logic [2:0] OP_PAUSE = 3'd4;
    localparam logic [2:0] OP_CLEAR = 3'd5;

    localparam logic [1:0] MODE_OFF   = 2'd0;
    localparam logic [1:0] MODE_PAUSE = 2'd1;
    localparam logic [1:0] MODE_READY = 2'd2;
    localparam logic [1:0] MODE_WORK  = 2'd3;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [31:0] time_now;
        logic [31:0] step_delay;
        logic        step_has_action;
    } t_in;

    typedef struct packed {
        logic       fired;
        logic [3:0] fired_step;
        logic [4:0] step_total;
        logic       add_failed;
        logic [1:0] run_mode;
    } t_out;

endpackage

// ===== hdl/timed_step_sequencer_top.sv =====
// Timed step sequencer top level: input register, sequencer core, result register.
// One beat in, one result beat out: every opcode yields exactly one result. A new item
// can be taken every clock cycle while the result side does not stall; the input register
// holds the item until the result register is free or draining, then the result register
// captures its result and holds it for as long as the result side stalls.
// The step table is a memory of MAX_STEPS entries with a registered read port; the entry
// of the coming step is prefetched, so the rate is one item per cycle while the result side does not stall.
// The table needs no clearing pass: only entries below the stored step count are ever used.
module timed_step_sequencer_top #(
    parameter int MAX_STEPS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  tss_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output tss_pkg::t_out o_data
);
    import tss_pkg::*;

    logic r_s1_vld;
    t_in  r_s1;
    logic r_out_vld;
    t_out r_out;
    logic w_adv;
    t_out w_res;

    // process the held beat when the result register is free or draining
    assign w_adv   = r_s1_vld && (!r_out_vld || i_ready);
    assign o_ready = !r_s1_vld || w_adv;

    tss_core #(
        .MAX_STEPS (MAX_STEPS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_item  (r_s1),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_ready) begin
                r_s1_vld <= i_valid;
            end
            if (w_adv) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_s1 <= i_data;
        end
        if (w_adv) begin
            r_out <= w_res;
        end
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

endmodule

// ===== hdl/tss_step_mem.sv =====
// Step table memory: one write port, one registered read port with write bypass.
module tss_step_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int WIDTH = 33
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // forward a same-address write so the read sees the new entry
    always_ff @(posedge i_clk) begin
        if (i_we && (i_waddr == i_raddr)) begin
            r_rdata <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/tss_core.sv =====
// Sequencer state and the per-beat update of mode, step and timing registers.
module tss_core #(
    parameter int MAX_STEPS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_adv,
    input  tss_pkg::t_in  i_item,
    output tss_pkg::t_out o_res
);
    import tss_pkg::*;
    `include "timed_step_sequencer_top_defines.svh"

    localparam int CW = $clog2(MAX_STEPS + 1);
    localparam int AW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;

    logic [1:0]    r_mode,    n_mode;
    logic [CW-1:0] r_count,   n_count;
    logic [CW-1:0] r_active,  n_active;
    logic [31:0]   r_start,   n_start;
    logic [31:0]   r_elapsed, n_elapsed;
    logic [31:0]   r_paused,  n_paused;
    logic [31:0]   r_prev,    n_prev;

    logic [31:0]   v_el;
    logic          v_go;
    logic          v_fired;
    logic          v_failed;
    logic          w_we;
    logic [32:0]   w_rdata;
    logic [AW-1:0] w_raddr;
    logic [CW+3:0] w_fstep_ext;
    logic [CW+4:0] w_total_ext;

    tss_step_mem #(
        .DEPTH (MAX_STEPS),
        .AW    (AW),
        .WIDTH (33)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata ({i_item.step_has_action, i_item.step_delay}),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_we    = i_adv && (i_item.opcode == OP_ADD) && (r_count < CW'(MAX_STEPS));
    // prefetch the entry of the step that will be current next cycle
    assign w_raddr = i_adv ? n_active[AW-1:0] : r_active[AW-1:0];

    always_comb begin
        n_mode    = r_mode;
        n_count   = r_count;
        n_active  = r_active;
        n_start   = r_start;
        n_elapsed = r_elapsed;
        n_paused  = r_paused;
        n_prev    = r_prev;
        v_el      = r_elapsed;
        v_go      = 1'b0;
        v_fired   = 1'b0;
        v_failed  = 1'b0;
        unique case (i_item.opcode)
            OP_TICK: begin
                unique case (r_mode)
                    MODE_PAUSE: begin
                        n_paused = r_paused + (i_item.time_now - r_prev);
                    end
                    MODE_READY: begin
                        n_start = i_item.time_now;
                        n_mode  = MODE_WORK;
                    end
                    MODE_WORK: begin
                        v_go = 1'b1;
                        if ((r_elapsed == 32'd0) || (r_active >= r_count)) begin
                            if ((r_active < r_count) && w_rdata[32]) begin
                                v_fired = 1'b1;
                                v_el    = r_elapsed + 32'd1;
                            end else begin
                                // halt the run as stop does
                                v_go      = 1'b0;
                                n_mode    = MODE_OFF;
                                n_active  = '0;
                                n_start   = '0;
                                n_elapsed = '0;
                                n_paused  = '0;
                            end
                        end
                        if (v_go) begin
                            if (v_el >= w_rdata[31:0]) begin
                                n_active  = r_active + CW'(1);
                                n_elapsed = '0;
                            end else begin
                                n_elapsed = v_el + (i_item.time_now - r_start);
                            end
                            n_start = i_item.time_now;
                        end
                    end
                    default: ;
                endcase
                n_prev = i_item.time_now;
            end
            OP_ADD: begin
                if (r_count >= CW'(MAX_STEPS)) begin
                    v_failed = 1'b1;
                end else begin
                    n_count = r_count + CW'(1);
                end
            end
            OP_START: begin
                if (r_mode == MODE_OFF) begin
                    n_mode   = MODE_READY;
                    n_active = '0;
                end else if (r_mode == MODE_PAUSE) begin
                    n_mode  = MODE_WORK;
                    n_start = r_start + r_paused;
                end
            end
            OP_STOP: begin
                n_mode    = MODE_OFF;
                n_active  = '0;
                n_start   = '0;
                n_elapsed = '0;
                n_paused  = '0;
            end
            OP_PAUSE: begin
                n_mode   = MODE_PAUSE;
                n_paused = '0;
            end
            OP_CLEAR: begin
                n_mode    = MODE_OFF;
                n_count   = '0;
                n_active  = '0;
                n_start   = '0;
                n_elapsed = '0;
                n_paused  = '0;
                n_prev    = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_OFF;
            r_count   <= '0;
            r_active  <= '0;
            r_start   <= '0;
            r_elapsed <= '0;
            r_paused  <= '0;
            r_prev    <= '0;
        end else if (i_adv) begin
            r_mode    <= n_mode;
            r_count   <= n_count;
            r_active  <= n_active;
            r_start   <= n_start;
            r_elapsed <= n_elapsed;
            r_paused  <= n_paused;
            r_prev    <= n_prev;
        end
    end

    assign w_fstep_ext = {4'b0000, (v_fired ? r_active : {CW{1'b0}})};
    assign w_total_ext = {5'b00000, n_count};

    assign o_res.fired      = v_fired;
    assign o_res.fired_step = w_fstep_ext[3:0];
    assign o_res.step_total = w_total_ext[4:0];
    assign o_res.add_failed = v_failed;
    assign o_res.run_mode   = n_mode;

    `TSS_ASSERT_ALWAYS(a_reset_to_off,
        !i_rst_n |=> ((r_mode == MODE_OFF) && (r_count == '0)),
        "not off and empty after reset")
    `TSS_ASSERT(a_active_in_table,
        (r_active <= r_count) && (r_count <= CW'(MAX_STEPS)),
        "active step beyond stored steps")
    `TSS_ASSERT(a_off_is_clean,
        (r_mode == MODE_OFF) |-> ((r_active == '0) && (r_elapsed == '0) && (r_paused == '0)),
        "stale run state while off")
    `TSS_ASSERT(a_ready_at_first,
        (r_mode == MODE_READY) |-> (r_active == '0),
        "ready with a step already advanced")
    `TSS_ASSERT(a_hold_when_idle,
        !i_adv |=> ($stable(r_mode) && $stable(r_count) && $stable(r_active)),
        "state moved without a beat")

endmodule
